// ===== rtl/mbd_pkg.sv =====
`default_nettype none

package mbd_pkg;

    // Number of buttons handled in one poll.
    localparam int BUTTONS    = 6;
    // Width of the raw level field; buttons beyond it read as low.
    localparam int LEVEL_BITS = 6;
    localparam int NOW_W      = 32;
    localparam int DEB_W      = 16;
    localparam int EVENT_W    = 3;

    localparam logic [DEB_W-1:0]   DEB_RESET = DEB_W'(50);
    localparam logic [EVENT_W-1:0] EVT_IDLE  = '0;

    // Verdict of one button for the current poll.
    typedef struct packed {
        logic changed;
        logic press;
        logic release_ok;
    } lane_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mbd_lane.sv =====
`default_nettype none

module mbd_lane
    import mbd_pkg::*;
(
    input  wire logic             lvl,
    input  wire logic             last_level,
    input  wire logic             is_pressed,
    input  wire logic [NOW_W-1:0] change_stamp,
    input  wire logic [NOW_W-1:0] now_ms,
    input  wire logic [DEB_W-1:0] debounce_ms,
    output lane_stat_t            stat
);

    logic [NOW_W-1:0] elapsed;
    logic             stable_long;

    // A level change restamps the button; the level comparison below ensures
    // that only an unchanged level can ever pass the threshold.
    assign elapsed     = now_ms - change_stamp;
    assign stable_long = (lvl == last_level) &&
                         (elapsed > {{(NOW_W-DEB_W){1'b0}}, debounce_ms});

    assign stat.changed    = (lvl != last_level);
    assign stat.press      = stable_long && !is_pressed && !lvl;
    assign stat.release_ok = stable_long && is_pressed && lvl;

endmodule

`default_nettype wire

// ===== rtl/multi_button_debounce_press_detect_core.sv =====
`default_nettype none

// Debounce and press detection for a bank of active-low buttons.
//
// Each input transaction on the s_ channel is one poll: the current wrapping
// millisecond time (s_now_ms) and the raw pin levels (s_levels). Every poll
// produces exactly one result transaction on the m_ channel: m_event_res is
// zero when nothing new happened, or button index plus one for the first
// button whose press became stable in this poll.
//
// The debounce threshold is written through the cfg_ channel (cfg_wdata);
// cfg_ready is always high. Write it only while no poll is in flight.
//
// The poll is captured in an input register, evaluated by one pass of
// per-button comparators and a priority chain, and the event lands in an
// output register, which drives m_valid. Throughput is one poll per cycle
// while the receiver keeps m_ready high. When the receiver stalls, the
// output register holds and the input register still absorbs one more
// poll before s_ready drops.
// Synchronous active-low reset releases all buttons, clears the timestamps,
// empties both registers and restores the threshold to 50 ms.

module multi_button_debounce_press_detect_core
    import mbd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [NOW_W-1:0]      s_now_ms,
    input  wire logic [LEVEL_BITS-1:0] s_levels,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [EVENT_W-1:0]         m_event_res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [DEB_W-1:0]      cfg_wdata
);

    // Configuration.
    logic [DEB_W-1:0] deb_reg;

    // Input register stage.
    logic                  in_valid_reg;
    logic [NOW_W-1:0]      now_reg;
    logic [LEVEL_BITS-1:0] levels_reg;

    // Output register stage.
    logic               out_valid_reg;
    logic [EVENT_W-1:0] event_reg;
    logic [EVENT_W-1:0] event_next;

    // Per-button state.
    logic [BUTTONS-1:0] last_reg,    last_next;
    logic [BUTTONS-1:0] pressed_reg, pressed_next;
    logic [NOW_W-1:0]   stamp_reg  [BUTTONS];
    logic [NOW_W-1:0]   stamp_next [BUTTONS];

    logic [BUTTONS-1:0] lvl_vec;
    lane_stat_t         stat [BUTTONS];

    logic advance;
    logic fire;

    // The output register can take a new event when it is empty or being
    // drained; the input register can refill when it is empty or under the same condition.
    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid     = out_valid_reg;
    assign m_event_res = event_reg;

    // One comparator lane per button. Buttons beyond the level field see a
    // constant low level.
    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        if (g < LEVEL_BITS) begin : g_pin
            assign lvl_vec[g] = levels_reg[g];
        end else begin : g_low
            assign lvl_vec[g] = 1'b0;
        end

        mbd_lane u_lane (
            .lvl          (lvl_vec[g]),
            .last_level   (last_reg[g]),
            .is_pressed   (pressed_reg[g]),
            .change_stamp (stamp_reg[g]),
            .now_ms       (now_reg),
            .debounce_ms  (deb_reg),
            .stat         (stat[g])
        );
    end

    // Priority chain: buttons are visited in index order, and the first new
    // press freezes every higher-indexed button for this poll.
    always_comb begin
        logic hit;
        hit          = 1'b0;
        event_next   = EVT_IDLE;
        last_next    = last_reg;
        pressed_next = pressed_reg;
        for (int i = 0; i < BUTTONS; i++) begin
            stamp_next[i] = stamp_reg[i];
            if (!hit) begin
                if (stat[i].changed) begin
                    stamp_next[i] = now_reg;
                end
                if (stat[i].press) begin
                    pressed_next[i] = 1'b1;
                    hit             = 1'b1;
                    event_next      = EVENT_W'(i + 1);
                end else if (stat[i].release_ok) begin
                    pressed_next[i] = 1'b0;
                end
                last_next[i] = lvl_vec[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg       <= DEB_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '1;
            pressed_reg   <= '0;
            for (int i = 0; i < BUTTONS; i++) begin
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                deb_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                last_reg      <= last_next;
                pressed_reg   <= pressed_next;
                for (int i = 0; i < BUTTONS; i++) begin
                    stamp_reg[i] <= stamp_next[i];
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg    <= s_now_ms;
            levels_reg <= s_levels;
        end
        if (fire) begin
            event_reg <= event_next;
        end
    end

    // A poll that is evaluated always leaves a result in the output register.
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (out_valid_reg && event_reg == $past(event_next)))
        else $error("evaluated poll did not produce its result");

    // At most one button can become pressed in one poll.
    a_one_press: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 ($countones(pressed_reg & ~$past(pressed_reg)) <= 1))
        else $error("more than one new press in one poll");

    // A new press is always reported with a nonzero event.
    a_press_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ((pressed_next & ~pressed_reg) != '0)) |-> (event_next != EVT_IDLE))
        else $error("new press without an event code");

    // A stalled poll in the input register is not dropped.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled poll was lost");

endmodule

`default_nettype wire
